/* rtl/pnm_pkg.sv */
`default_nettype none
package pnm_pkg;

    localparam int NUM_W = 16;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
    localparam int JOBQ_DEPTH = 2;

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_ONE = 8'h31;
    localparam logic [7:0] CH_SIX = 8'h36;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_NOT_PNM = 3'd1;
    localparam logic [2:0] ERR_TYPE = 3'd2;
    localparam logic [2:0] ERR_SIZE = 3'd3;
    localparam logic [2:0] ERR_MAXVAL = 3'd4;

    localparam logic [2:0] FMT_P1 = 3'd1;
    localparam logic [2:0] FMT_P2 = 3'd2;
    localparam logic [2:0] FMT_P3 = 3'd3;
    localparam logic [2:0] FMT_P4 = 3'd4;
    localparam logic [2:0] FMT_P5 = 3'd5;
    localparam logic [2:0] FMT_P6 = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } pnm_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] column;
        logic [15:0] row_index;
        logic        last_of_run;
        logic        last_pixel;
        logic [2:0]  error_code;
        logic [2:0]  format;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } pnm_res_t;

    // One classified beat of work for the back end.
    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       err;
        logic [2:0]       fmt;
        logic [15:0]      width;
        logic [15:0]      height;
        logic [15:0]      col;
        logic [15:0]      row;
        logic             last;
        logic [NUM_W-1:0] c0;
        logic [NUM_W-1:0] c1;
        logic [NUM_W-1:0] c2;
        logic             color;
        logic             scale;
        logic [NUM_W-1:0] maxval;
        logic             burst;
        logic [7:0]       bits;
        logic [3:0]       cnt;
    } pnm_job_t;

endpackage
`default_nettype wire

/* rtl/pnm_front.sv */
`default_nettype none
module pnm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire pnm_pkg::pnm_in_t  in_beat,
    output pnm_pkg::pnm_job_t      job,
    output logic                   job_valid
);

    typedef enum logic [7:0] {
        PH_MAGIC  = 8'b0000_0001,
        PH_TYPE   = 8'b0000_0010,
        PH_WIDTH  = 8'b0000_0100,
        PH_HEIGHT = 8'b0000_1000,
        PH_MAXVAL = 8'b0001_0000,
        PH_EOL    = 8'b0010_0000,
        PH_RASTER = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    localparam int NW = pnm_pkg::NUM_W;

    phase_t phase_reg, phase_next;
    logic cmt_reg, cmt_next, dseen_reg, dseen_next;
    logic [2:0] typ_reg, typ_next;
    logic [15:0] w_reg, w_next, h_reg, h_next, col_reg, col_next, row_reg, row_next;
    logic [NW-1:0] mv_reg, mv_next, acc_reg, acc_next, pr_reg, pr_next, pg_reg, pg_next;
    logic [1:0] ci_reg, ci_next;

    phase_t ph;
    logic cmt, dseen;
    logic [2:0] typ;
    logic [15:0] w, h, col, row;
    logic [NW-1:0] mv, acc, pr, pg;
    logic [1:0] ci;

    logic [7:0] b;
    logic is_digit, is_sp;
    logic nf_done, nf_cmt, nf_dseen;
    logic [NW-1:0] nf_acc, nf_val;
    logic [NW+3:0] mul10;
    logic do_pix, pix_last;
    logic [NW-1:0] pix_c0, pix_c1, pix_c2;
    logic [16:0] left;
    logic [3:0] bcnt;
    logic [16:0] bend;

    always_comb
    begin
        b = in_beat.data_byte;
        if (in_beat.start_of_file)
        begin
            ph = PH_MAGIC; cmt = 1'b0; dseen = 1'b0; typ = '0; w = '0; h = '0;
            mv = NW'(255); acc = '0; col = '0; row = '0; ci = '0; pr = '0; pg = '0;
        end
        else
        begin
            ph = phase_reg; cmt = cmt_reg; dseen = dseen_reg; typ = typ_reg;
            w = w_reg; h = h_reg; mv = mv_reg; acc = acc_reg; col = col_reg;
            row = row_reg; ci = ci_reg; pr = pr_reg; pg = pg_reg;
        end

        // decimal number reader
        is_digit = (b >= pnm_pkg::CH_ZERO) && (b <= pnm_pkg::CH_NINE);
        is_sp = (b == pnm_pkg::CH_SPACE) || ((b >= pnm_pkg::CH_TAB) && (b <= pnm_pkg::CH_CR));
        nf_done = 1'b0; nf_val = '0; nf_cmt = cmt; nf_acc = acc; nf_dseen = dseen;
        mul10 = (NW+4)'(acc) * (NW+4)'(10) + (NW+4)'(b - pnm_pkg::CH_ZERO);
        if (cmt)
        begin
            if (b == pnm_pkg::CH_LF)
                nf_cmt = 1'b0;
        end
        else if (is_digit)
        begin
            nf_acc = (mul10 > (NW+4)'(pnm_pkg::NUM_MAX)) ? pnm_pkg::NUM_MAX : mul10[NW-1:0];
            nf_dseen = 1'b1;
        end
        else if (dseen)
        begin
            nf_done = 1'b1; nf_val = acc; nf_acc = '0; nf_dseen = 1'b0;
            if (b == pnm_pkg::CH_HASH)
                nf_cmt = 1'b1;
        end
        else if (is_sp)
        begin
        end
        else if (b == pnm_pkg::CH_HASH)
            nf_cmt = 1'b1;
        else
            nf_done = 1'b1;

        pix_last = (17'(col) + 17'd1 >= 17'(w)) && (17'(row) + 17'd1 >= 17'(h));
        left = 17'(w) - 17'(col);
        bcnt = (left > 17'd8) ? 4'd8 : left[3:0];
        bend = 17'(col) + 17'(bcnt);

        job = '0;
        job_valid = 1'b0;
        do_pix = 1'b0;
        pix_c0 = '0; pix_c1 = '0; pix_c2 = '0;

        unique case (ph)
            PH_MAGIC:
            begin
                if (cmt)
                begin
                    if (b == pnm_pkg::CH_LF)
                        cmt = 1'b0;
                end
                else if (b == pnm_pkg::CH_HASH)
                    cmt = 1'b1;
                else if (is_sp)
                begin
                end
                else if (b == pnm_pkg::CH_P)
                    ph = PH_TYPE;
                else
                begin
                    job.kind = pnm_pkg::KIND_ERROR; job.err = pnm_pkg::ERR_NOT_PNM;
                    job_valid = 1'b1; ph = PH_DONE;
                end
            end
            PH_TYPE:
            begin
                if ((b >= pnm_pkg::CH_ONE) && (b <= pnm_pkg::CH_SIX))
                begin
                    typ = 3'(b - pnm_pkg::CH_ZERO); ph = PH_WIDTH;
                end
                else
                begin
                    job.kind = pnm_pkg::KIND_ERROR; job.err = pnm_pkg::ERR_TYPE;
                    job_valid = 1'b1; ph = PH_DONE;
                end
            end
            PH_WIDTH:
            begin
                cmt = nf_cmt; acc = nf_acc; dseen = nf_dseen;
                if (nf_done)
                begin
                    w = 16'(nf_val); ph = PH_HEIGHT;
                end
            end
            PH_HEIGHT, PH_MAXVAL:
            begin
                cmt = nf_cmt; acc = nf_acc; dseen = nf_dseen;
                if (nf_done)
                begin
                    if (ph == PH_HEIGHT)
                        h = 16'(nf_val);
                    else
                        mv = nf_val;
                    if ((ph == PH_HEIGHT) && ((w == '0) || (h == '0)))
                    begin
                        job.kind = pnm_pkg::KIND_ERROR; job.err = pnm_pkg::ERR_SIZE;
                        job_valid = 1'b1; ph = PH_DONE;
                    end
                    else if ((ph == PH_MAXVAL) && (mv == '0))
                    begin
                        job.kind = pnm_pkg::KIND_ERROR; job.err = pnm_pkg::ERR_MAXVAL;
                        job_valid = 1'b1; ph = PH_DONE;
                    end
                    else if ((ph == PH_HEIGHT) && (typ != pnm_pkg::FMT_P1)
                             && (typ != pnm_pkg::FMT_P4))
                        ph = PH_MAXVAL;
                    else
                    begin
                        // header: open the raster
                        job.kind = pnm_pkg::KIND_HEADER; job_valid = 1'b1;
                        col = '0; row = '0; ci = '0;
                        if (typ >= pnm_pkg::FMT_P4)
                        begin
                            cmt = 1'b0;
                            ph = (b == pnm_pkg::CH_LF) ? PH_RASTER : PH_EOL;
                        end
                        else
                            ph = PH_RASTER;
                    end
                end
            end
            PH_EOL:
            begin
                if (b == pnm_pkg::CH_LF)
                    ph = PH_RASTER;
            end
            PH_RASTER:
            begin
                priority if (typ == pnm_pkg::FMT_P4)
                begin
                    job.kind = pnm_pkg::KIND_PIXEL; job.burst = 1'b1; job.bits = b;
                    job.cnt = bcnt; job.col = col; job.row = row;
                    job.last = (17'(row) + 17'd1 >= 17'(h)) && (bend >= 17'(w));
                    job_valid = 1'b1;
                    if (bend >= 17'(w))
                    begin
                        col = '0; row = row + 16'd1;
                    end
                    else
                        col = bend[15:0];
                    if (job.last)
                        ph = PH_DONE;
                end
                else if ((typ == pnm_pkg::FMT_P5) || (typ == pnm_pkg::FMT_P6))
                begin
                    if (typ == pnm_pkg::FMT_P5)
                    begin
                        do_pix = 1'b1; pix_c0 = NW'(b);
                    end
                    else
                    begin
                        unique case (ci)
                            2'd0: begin pr = NW'(b); ci = 2'd1; end
                            2'd1: begin pg = NW'(b); ci = 2'd2; end
                            default:
                            begin
                                ci = 2'd0; do_pix = 1'b1;
                                pix_c0 = pr; pix_c1 = pg; pix_c2 = NW'(b);
                            end
                        endcase
                    end
                end
                else
                begin
                    cmt = nf_cmt; acc = nf_acc; dseen = nf_dseen;
                    if (nf_done)
                    begin
                        if (typ == pnm_pkg::FMT_P3)
                        begin
                            unique case (ci)
                                2'd0: begin pr = nf_val; ci = 2'd1; end
                                2'd1: begin pg = nf_val; ci = 2'd2; end
                                default:
                                begin
                                    ci = 2'd0; do_pix = 1'b1;
                                    pix_c0 = pr; pix_c1 = pg; pix_c2 = nf_val;
                                end
                            endcase
                        end
                        else if (typ == pnm_pkg::FMT_P1)
                        begin
                            do_pix = 1'b1;
                            pix_c0 = (nf_val != '0) ? '0 : NW'(255);
                        end
                        else
                        begin
                            do_pix = 1'b1; pix_c0 = nf_val;
                        end
                    end
                end
                if (do_pix)
                begin
                    job.kind = pnm_pkg::KIND_PIXEL; job.col = col; job.row = row;
                    job.last = pix_last; job.c0 = pix_c0; job.c1 = pix_c1;
                    job.c2 = pix_c2;
                    job.color = (typ == pnm_pkg::FMT_P3) || (typ == pnm_pkg::FMT_P6);
                    job.scale = (typ != pnm_pkg::FMT_P1);
                    job_valid = 1'b1;
                    if (17'(col) + 17'd1 >= 17'(w))
                    begin
                        col = '0; row = row + 16'd1;
                    end
                    else
                        col = col + 16'd1;
                    if (pix_last)
                        ph = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        job.fmt = typ; job.width = w; job.height = h; job.maxval = mv;

        phase_next = ph; cmt_next = cmt; dseen_next = dseen; typ_next = typ;
        w_next = w; h_next = h; mv_next = mv; acc_next = acc; col_next = col;
        row_next = row; ci_next = ci; pr_next = pr; pg_next = pg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC; cmt_reg <= 1'b0; dseen_reg <= 1'b0; typ_reg <= '0;
            w_reg <= '0; h_reg <= '0; mv_reg <= NW'(255); acc_reg <= '0;
            col_reg <= '0; row_reg <= '0; ci_reg <= '0; pr_reg <= '0; pg_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next; cmt_reg <= cmt_next; dseen_reg <= dseen_next;
            typ_reg <= typ_next; w_reg <= w_next; h_reg <= h_next; mv_reg <= mv_next;
            acc_reg <= acc_next; col_reg <= col_next; row_reg <= row_next;
            ci_reg <= ci_next; pr_reg <= pr_next; pg_reg <= pg_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/pnm_job_q.sv */
`default_nettype none
module pnm_job_q (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire pnm_pkg::pnm_job_t push_job,
    input  wire logic              pop,
    output pnm_pkg::pnm_job_t      head,
    output logic                   empty,
    output logic                   full
);

    localparam int D = pnm_pkg::JOBQ_DEPTH;
    localparam int AW = (D > 1) ? $clog2(D) : 1;

    pnm_pkg::pnm_job_t mem [D];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full = (cnt_reg == (AW+1)'(D));
    assign head = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(D - 1)) ? '0 : wp_reg + AW'(1);
            if (pop)
                rp_reg <= (rp_reg == AW'(D - 1)) ? '0 : rp_reg + AW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

endmodule
`default_nettype wire

/* rtl/pnm_back.sv */
`default_nettype none
module pnm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pnm_pkg::pnm_job_t head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output pnm_pkg::pnm_res_t      res_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    localparam int NW = pnm_pkg::NUM_W;

    state_t state_reg, state_next;
    pnm_pkg::pnm_job_t job_reg;
    logic [7:0] val_reg [3];
    logic [1:0] ci_reg;
    logic [3:0] k_reg;
    logic [2:0] step_reg;
    logic [NW-1:0] rem_reg;
    logic [7:0] low_reg;
    logic out_valid_reg;
    pnm_pkg::pnm_res_t out_reg;

    logic [NW-1:0] comp;
    logic [NW+7:0] prod;
    logic [NW:0] trial;
    logic ge;
    logic out_free, last_comp, burst_end;
    logic [7:0] bit_val;

    assign pop = (state_reg == S_IDLE) && !empty;
    assign res_valid = out_valid_reg;
    assign res_data = out_reg;
    assign out_free = !out_valid_reg || !res_stall;

    always_comb
    begin
        unique case (ci_reg)
            2'd0: comp = job_reg.c0;
            2'd1: comp = job_reg.c1;
            default: comp = job_reg.c2;
        endcase
        prod = (NW+8)'(comp) * (NW+8)'(pnm_pkg::FULL_SCALE);
        trial = {rem_reg, low_reg[7]};
        ge = (trial >= (NW+1)'(job_reg.maxval));
        last_comp = !job_reg.color || (ci_reg == 2'd2);
        burst_end = (k_reg == job_reg.cnt - 4'd1);
        bit_val = job_reg.bits[3'd7 - k_reg[2:0]] ? 8'd0 : pnm_pkg::FULL_SCALE;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (!empty)
                    state_next = ((head.kind == pnm_pkg::KIND_PIXEL) && !head.burst)
                                 ? S_PREP : S_EMIT;
            S_PREP:
                if (job_reg.scale && (comp < job_reg.maxval))
                    state_next = S_DIV;
                else if (last_comp)
                    state_next = S_EMIT;
            S_DIV:
                if ((step_reg == 3'd7) && last_comp)
                    state_next = S_EMIT;
                else if (step_reg == 3'd7)
                    state_next = S_PREP;
            S_EMIT:
                if (out_free && (!job_reg.burst || burst_end))
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_EMIT) && out_free)
                out_valid_reg <= 1'b1;
            else if (!res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg <= head;
                ci_reg <= 2'd0;
                k_reg <= 4'd0;
            end
            S_PREP:
            begin
                step_reg <= 3'd0;
                rem_reg <= prod[NW+7:8];
                low_reg <= prod[7:0];
                if (!(job_reg.scale && (comp < job_reg.maxval)))
                begin
                    // saturate or pass through unscaled
                    val_reg[ci_reg] <= job_reg.scale ? pnm_pkg::FULL_SCALE : comp[7:0];
                    ci_reg <= ci_reg + 2'd1;
                end
            end
            S_DIV:
            begin
                // one quotient bit a cycle
                rem_reg <= ge ? NW'(trial - (NW+1)'(job_reg.maxval)) : trial[NW-1:0];
                low_reg <= {low_reg[6:0], ge};
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    val_reg[ci_reg] <= {low_reg[6:0], ge};
                    ci_reg <= ci_reg + 2'd1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_reg.kind <= job_reg.kind;
                    out_reg.error_code <= job_reg.err;
                    out_reg.format <= job_reg.fmt;
                    out_reg.image_width <= job_reg.width;
                    out_reg.image_height <= job_reg.height;
                    out_reg.row_index <= job_reg.row;
                    if (job_reg.burst)
                    begin
                        out_reg.red <= bit_val; out_reg.green <= bit_val;
                        out_reg.blue <= bit_val;
                        out_reg.column <= job_reg.col + 16'(k_reg);
                        out_reg.last_of_run <= burst_end;
                        out_reg.last_pixel <= job_reg.last && burst_end;
                        k_reg <= k_reg + 4'd1;
                    end
                    else
                    begin
                        // header and error beats carry no color
                        out_reg.red <= (job_reg.kind != pnm_pkg::KIND_PIXEL) ? 8'd0
                                       : val_reg[0];
                        out_reg.green <= (job_reg.kind != pnm_pkg::KIND_PIXEL) ? 8'd0
                                         : (job_reg.color ? val_reg[1] : val_reg[0]);
                        out_reg.blue <= (job_reg.kind != pnm_pkg::KIND_PIXEL) ? 8'd0
                                        : (job_reg.color ? val_reg[2] : val_reg[0]);
                        out_reg.column <= job_reg.col;
                        out_reg.last_of_run <= 1'b1;
                        out_reg.last_pixel <= job_reg.last;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/pnm_image_stream_decoder.sv */
// PNM stream decoder (P1..P6). Feed one file byte per beat on the byte channel; raise
// start_of_file on the first byte of each file. Results leave on the res channel: a header
// beat, then one RGB pixel beat per image position in raster order, or one error beat after
// which the rest of the file is dropped. A byte is taken while the two-entry job queue has
// room. The back end then dequeues each result and emits it; a sample that needs the
// 255/maxval scaling first passes a setup step and then the shared divider, which yields one
// quotient bit a cycle. A P4 byte yields up to eight pixels at one per cycle after its
// dequeue while the res side does not stall. Samples at or above maxval and P1 values skip
// the divider and leave the setup step directly.
`default_nettype none
module pnm_image_stream_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire pnm_pkg::pnm_in_t  byte_data,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output pnm_pkg::pnm_res_t      res_data
);

    pnm_pkg::pnm_job_t job, head;
    logic job_valid, accept, push, pop, q_empty, q_full;

    // hold the byte side while the queue is full
    assign byte_stall = q_full;
    assign accept = byte_valid && !q_full;
    assign push = accept && job_valid;

    pnm_front u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept), .in_beat(byte_data),
        .job(job), .job_valid(job_valid)
    );

    pnm_job_q u_q (
        .clk(clk), .rst_n(rst_n), .push(push), .push_job(job), .pop(pop),
        .head(head), .empty(q_empty), .full(q_full)
    );

    pnm_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .empty(q_empty), .pop(pop),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
    );

endmodule
`default_nettype wire

/* rtl/pnm_checker.sv */
`default_nettype none
module pnm_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              res_valid,
    input wire logic              res_stall,
    input wire pnm_pkg::pnm_res_t res_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    a_lastpix: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.last_pixel |->
            res_data.kind == pnm_pkg::KIND_PIXEL && res_data.last_of_run)
        else $error("last pixel flag on a non-final beat");

    a_errcode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.kind == pnm_pkg::KIND_ERROR) ==
                       (res_data.error_code != pnm_pkg::ERR_NONE)))
        else $error("error code does not match beat kind");

    a_nonpix: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind != pnm_pkg::KIND_PIXEL |->
            res_data.last_of_run && res_data.red == 8'd0 && res_data.column == 16'd0)
        else $error("header or error beat carries pixel data");

endmodule

bind pnm_image_stream_decoder pnm_checker u_pnm_checker (
    .clk(clk), .rst_n(rst_n), .res_valid(res_valid), .res_stall(res_stall),
    .res_data(res_data)
);
`default_nettype wire
